// ===== hw/rtl/lti_pkg.sv =====
// Package for the linear table interpolator: word types and shared constants.
// Depends on nothing; used by every module of the block.
package lti_pkg;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef enum logic {
    CFG_KNOT_COUNT  = 1'b0,
    CFG_EXTRAP_MODE = 1'b1
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 7;

  typedef struct packed {
    logic               mode;
    logic [5:0]         knot_index;
    logic signed [31:0] knot_x;
    logic signed [31:0] knot_y;
    logic signed [31:0] query_x;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [5:0]         segment;
    logic               overflow;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDEND,
    ST_SEARCH,
    ST_RDSEG,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } back_state_e;

endpackage

// ===== hw/rtl/lti_front.sv =====
// Front part: accepts words, stores knot writes and queues queries.
// Depends on lti_pkg; feeds lti_back through a two-entry query queue.
module lti_front #(
  parameter int unsigned QDEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  input  lti_pkg::in_word_t in_word_i,
  output logic             full,
  output logic             wr_en_o,
  output logic [5:0]       wr_idx_o,
  output logic [31:0]      wr_x_o,
  output logic [31:0]      wr_y_o,
  output logic             q_valid_o,
  output logic [31:0]      q_x_o,
  input  logic             q_take_i,
  input  logic             busy_i
);
  import lti_pkg::*;

  logic [31:0] qx_q [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] rd_q, rd_d, wp_q, wp_d;
  logic [$clog2(QDEPTH):0]   cnt_q, cnt_d;
  logic acc, is_q;

  // A knot write waits until no query is queued or in progress.
  assign full = (cnt_q == ($clog2(QDEPTH)+1)'(QDEPTH)) ||
                (!is_q && ((cnt_q != '0) || busy_i));
  assign acc  = push && !full;
  assign is_q = (in_word_i.mode == MODE_QUERY);

  assign wr_en_o  = acc && !is_q;
  assign wr_idx_o = in_word_i.knot_index;
  assign wr_x_o   = in_word_i.knot_x;
  assign wr_y_o   = in_word_i.knot_y;

  assign q_valid_o = (cnt_q != '0);
  assign q_x_o     = qx_q[rd_q];

  always_comb begin
    rd_d  = rd_q;
    wp_d  = wp_q;
    cnt_d = cnt_q;
    if (acc && is_q) begin
      wp_d  = wp_q + 1'b1;
      cnt_d = cnt_d + 1'b1;
    end
    if (q_take_i && q_valid_o) begin
      rd_d  = rd_q + 1'b1;
      cnt_d = cnt_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wp_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wp_q  <= wp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && is_q) begin
      qx_q[wp_q] <= in_word_i.query_x;
    end
  end

endmodule

// ===== hw/rtl/lti_back.sv =====
// Back part: table memories, binary search, multiply, serial divide, saturation.
// Depends on lti_pkg; takes queries from lti_front and writes a one-word output register.
module lti_back #(
  parameter int unsigned MAX_KNOTS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [5:0]          wr_idx_i,
  input  logic [31:0]         wr_x_i,
  input  logic [31:0]         wr_y_i,
  input  logic                q_valid_i,
  input  logic [31:0]         q_x_i,
  output logic                q_take_o,
  output logic                busy_o,
  input  logic [6:0]          knot_count_i,
  input  logic                extrap_i,
  output logic                empty,
  input  logic                pop,
  output lti_pkg::out_word_t  out_word_o
);
  import lti_pkg::*;

  localparam int unsigned AW = $clog2(MAX_KNOTS);
  localparam int unsigned CW = (AW + 1 > 7) ? AW + 1 : 7;

  logic [31:0] xmem [MAX_KNOTS];
  logic [31:0] ymem [MAX_KNOTS];
  logic [AW-1:0] ra_q, ra_d;
  logic [31:0] rx_q, ry_q;

  back_state_e st_q, st_d;
  logic [1:0]  ph_q, ph_d;
  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d, last_q, last_d;
  logic signed [32:0] xq_q, xq_d;
  logic signed [32:0] x0_q, x0_d, y0_q, y0_d, x1_q, x1_d, y1_q, y1_d;
  logic [63:0] prod_q, prod_d;
  logic [31:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [6:0]  dc_q, dc_d;
  out_word_t   r_q, r_d;
  out_word_t   o_q, o_d;
  logic        full_q, full_d;

  logic [CW-1:0] n_used;
  logic [AW-1:0] mid, seg;
  logic signed [32:0] den, dx, dy, x_rd, y_rd;
  logic [32:0] mdx, mdy, mden, rsh;
  logic signed [35:0] res;

  always_comb begin
    if ({{(CW-7){1'b0}}, knot_count_i} < CW'(2)) n_used = CW'(2);
    else if ({{(CW-7){1'b0}}, knot_count_i} > CW'(MAX_KNOTS)) n_used = CW'(MAX_KNOTS);
    else n_used = CW'(knot_count_i);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && ({{(CW-6){1'b0}}, wr_idx_i} < CW'(MAX_KNOTS))) begin
      xmem[wr_idx_i[AW-1:0]] <= wr_x_i;
      ymem[wr_idx_i[AW-1:0]] <= wr_y_i;
    end
    rx_q <= xmem[ra_d];
    ry_q <= ymem[ra_d];
  end

  assign x_rd = {rx_q[31], rx_q};
  assign y_rd = {ry_q[31], ry_q};
  assign mid  = AW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
  assign seg  = lo_q;
  assign den  = x1_q - x0_q;
  assign dx   = xq_q - x0_q;
  assign dy   = y1_q - y0_q;
  assign mdx  = dx[32] ? 33'(-dx) : 33'(dx);
  assign mdy  = dy[32] ? 33'(-dy) : 33'(dy);
  assign mden = den[32] ? 33'(-den) : 33'(den);
  assign rsh  = {rem_q[31:0], prod_q[63]};

  assign empty      = !full_q;
  assign out_word_o = o_q;
  assign busy_o     = (st_q != ST_IDLE);

  always_comb begin
    st_d = st_q; ph_d = ph_q; lo_d = lo_q; hi_d = hi_q; last_d = last_q;
    xq_d = xq_q; x0_d = x0_q; y0_d = y0_q; x1_d = x1_q; y1_d = y1_q;
    prod_d = prod_q; den_d = den_q; neg_d = neg_q;
    quo_d = quo_q; rem_d = rem_q; dc_d = dc_q; r_d = r_q; o_d = o_q; full_d = full_q;
    ra_d = ra_q; q_take_o = 1'b0; res = '0;
    if (pop && full_q) full_d = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_take_o = 1'b1;
          xq_d = {q_x_i[31], q_x_i};
          last_d = AW'(n_used - CW'(1));
          ra_d = '0; ph_d = '0;
          st_d = ST_RDEND;
        end
      end
      ST_RDEND: begin
        // Phase 0 issues x[0]; phase 1 captures it and issues x[n-1]; phase 2 decides.
        ph_d = ph_q + 1'b1;
        ra_d = (ph_q == 2'd0) ? '0 : last_q;
        if (ph_q == 2'd1) begin
          x0_d = x_rd; y0_d = y_rd;
        end else if (ph_q == 2'd2) begin
          x1_d = x_rd; y1_d = y_rd;
          lo_d = '0; hi_d = last_q;
          if (xq_q <= x0_q) begin
            lo_d = '0; st_d = ST_RDSEG;
          end else if (xq_q >= x_rd) begin
            lo_d = AW'(last_q - 1'b1); st_d = ST_RDSEG;
          end else begin
            st_d = ST_SEARCH; ph_d = '0;
          end
          if (extrap_i && xq_q <= x0_q) begin
            r_d = '{value: y0_q[31:0], segment: '0, overflow: 1'b0};
            st_d = ST_OUT;
          end else if (extrap_i && xq_q >= x_rd) begin
            r_d = '{value: y_rd[31:0], segment: 6'(AW'(last_q - 1'b1)),
                    overflow: 1'b0};
            st_d = ST_OUT;
          end
          ph_d = '0;
        end
      end
      ST_SEARCH: begin
        if (hi_q - lo_q <= AW'(1)) begin
          st_d = ST_RDSEG; ph_d = '0;
        end else if (ph_q == 2'd0) begin
          ra_d = mid; ph_d = 2'd1;
        end else if (ph_q == 2'd1) begin
          ph_d = 2'd2;
        end else begin
          if (x_rd <= xq_q) lo_d = mid; else hi_d = mid;
          ph_d = 2'd0;
        end
      end
      ST_RDSEG: begin
        ph_d = ph_q + 1'b1;
        if (ph_q == 2'd0) begin
          ra_d = seg;
        end else if (ph_q == 2'd1) begin
          x0_d = x_rd; y0_d = y_rd;
          ra_d = AW'(seg + 1'b1);
        end else begin
          x1_d = x_rd; y1_d = y_rd; st_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d = mdx[31:0] * mdy[31:0];
        if (mdx[32] || mdy[32]) prod_d = {mdx[31:0], 32'd0};
        den_d = mden[31:0];
        neg_d = (dx[32] != dy[32]) != den[32];
        quo_d = '0; rem_d = '0; dc_d = '0;
        if (den == '0) begin
          r_d = '{value: y0_q[31:0], segment: 6'(seg), overflow: 1'b0};
          st_d = ST_OUT;
        end else begin
          st_d = ST_DIV;
        end
      end
      ST_DIV: begin
        prod_d = {prod_q[62:0], 1'b0};
        if ({1'b0, den_q} == 33'd0 || rsh >= {1'b0, den_q}) begin
          rem_d = rsh - {1'b0, den_q};
          quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = rsh;
          quo_d = {quo_q[62:0], 1'b0};
        end
        dc_d = dc_q + 1'b1;
        if (dc_q == 7'd63) st_d = ST_FIN;
      end
      ST_FIN: begin
        if (quo_q[63:33] != '0) begin
          res = neg_q ? 36'sh800000000 : 36'sh7FFFFFFFF;
        end else begin
          res = neg_q ? 36'(y0_q) - $signed({3'b0, quo_q[32:0]})
                      : 36'(y0_q) + $signed({3'b0, quo_q[32:0]});
        end
        r_d.segment = 6'(seg);
        if (res > 36'sd2147483647) begin
          r_d.value = 32'h7FFFFFFF; r_d.overflow = 1'b1;
        end else if (res < -36'sd2147483648) begin
          r_d.value = 32'h80000000; r_d.overflow = 1'b1;
        end else begin
          r_d.value = res[31:0]; r_d.overflow = 1'b0;
        end
        st_d = ST_OUT;
      end
      ST_OUT: begin
        if (!full_q || pop) begin
          o_d = r_q; full_d = 1'b1; st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; ph_q <= '0; full_q <= 1'b0; ra_q <= '0;
    end else begin
      st_q <= st_d; ph_q <= ph_d; full_q <= full_d; ra_q <= ra_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; hi_q <= hi_d; last_q <= last_d; xq_q <= xq_d;
    x0_q <= x0_d; y0_q <= y0_d; x1_q <= x1_d; y1_q <= y1_d;
    prod_q <= prod_d; den_q <= den_d; neg_q <= neg_d;
    quo_q <= quo_d; rem_q <= rem_d; dc_q <= dc_d; r_q <= r_d; o_q <= o_d;
  end

endmodule

// ===== hw/rtl/linear_table_interpolator_unit.sv =====
// Top level of the linear table interpolator: configuration registers and wiring.
// Depends on lti_pkg, lti_front and lti_back.
// A knot write is taken once no query is queued or in progress, so every query sees the
// table as it stood when the query was accepted. From acceptance to its result word, a
// query at most leaves the queue, reads the end knots, runs a binary search, reads the
// segment, multiplies, runs the bit-serial restoring divider, saturates and loads the
// output register; the back part takes no new query until it is through with the last one.
// Up to two queries wait ahead of the back part, and a finished result waits in a staging
// register behind the output register.
module linear_table_interpolator_unit #(
  parameter int unsigned MAX_KNOTS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  lti_pkg::in_word_t               in_word_i,
  output logic                            empty,
  input  logic                            pop,
  output lti_pkg::out_word_t              out_word_o,
  input  logic                            cfg_we_i,
  input  logic [lti_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [lti_pkg::CfgDataW-1:0]    cfg_data_i
);
  import lti_pkg::*;

  logic [6:0] knot_count_q;
  logic       extrap_q;
  logic       wr_en, q_valid, q_take, busy;
  logic [5:0] wr_idx;
  logic [31:0] wr_x, wr_y, q_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knot_count_q <= 7'd2;
      extrap_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KNOT_COUNT:  knot_count_q <= cfg_data_i;
        CFG_EXTRAP_MODE: extrap_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  lti_front u_front (
    .clk_i, .rst_ni, .push, .in_word_i, .full,
    .wr_en_o(wr_en), .wr_idx_o(wr_idx), .wr_x_o(wr_x), .wr_y_o(wr_y),
    .q_valid_o(q_valid), .q_x_o(q_x), .q_take_i(q_take), .busy_i(busy)
  );

  lti_back #(.MAX_KNOTS(MAX_KNOTS)) u_back (
    .clk_i, .rst_ni,
    .wr_en_i(wr_en), .wr_idx_i(wr_idx), .wr_x_i(wr_x), .wr_y_i(wr_y),
    .q_valid_i(q_valid), .q_x_i(q_x), .q_take_o(q_take), .busy_o(busy),
    .knot_count_i(knot_count_q), .extrap_i(extrap_q),
    .empty, .pop, .out_word_o
  );

endmodule

// ===== hw/rtl/lti_checker.sv =====
// Port-level checker for the linear table interpolator, bound to the top level.
// Depends on lti_pkg and linear_table_interpolator_unit.
module lti_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input lti_pkg::out_word_t out_word_o
);
  import lti_pkg::*;

  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(out_word_o))
    else $error("result word changed while waiting");

  a_keep_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result dropped without pop");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.overflow) |->
      (out_word_o.value == 32'h7FFFFFFF || out_word_o.value == 32'h80000000))
    else $error("overflow without saturated value");

  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_word_o.segment <= 6'd62))
    else $error("segment index out of range");

endmodule

bind linear_table_interpolator_unit lti_checker u_lti_checker (
  .clk_i, .rst_ni, .empty, .pop, .out_word_o
);
